@@ hw/rtl/ilie_pkg.sv @@
// shared types and constants for the indexed list insert/erase block
package ilie_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 9;
  localparam int COUNT_W      = 9;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_PUSH,
    DP_INS_START,
    DP_INS_STEP,
    DP_INS_PLACE,
    DP_ERS_START,
    DP_POP_START,
    DP_ERS_FIRST,
    DP_ERS_STEP,
    DP_OUTPUT
  } dp_cmd_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    logic    ins_end;
    logic    up_last;
    logic    dn_more1;
    logic    dn_more2;
    logic    out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/ilie_if.sv @@
// request and response channel interfaces
interface ilie_req_if;
  logic                                 valid;
  logic                                 ready;
  ilie_pkg::op_t                        op;
  logic signed [ilie_pkg::VALUE_W-1:0]  value;
  logic [ilie_pkg::POS_W-1:0]           position;

  modport source(output valid, op, value, position, input ready);
  modport sink(input valid, op, value, position, output ready);
endinterface

interface ilie_rsp_if;
  logic                                 valid;
  logic                                 ready;
  ilie_pkg::status_t                    status;
  logic signed [ilie_pkg::VALUE_W-1:0]  removed_value;
  logic [ilie_pkg::COUNT_W-1:0]         count;

  modport source(output valid, status, removed_value, count, input ready);
  modport sink(input valid, status, removed_value, count, output ready);
endinterface

@@ hw/rtl/ilie_ram.sv @@
// generic simple dual-port ram with registered read
module ilie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

@@ hw/rtl/ilie_ctrl.sv @@
// request sequencer for the list datapath
module ilie_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilie_pkg::dp_stat_t stat,
  output ilie_pkg::dp_cmd_t  cmd
);
  import ilie_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_PLACE,
    S_ERS_FIRST,
    S_ERS_SHIFT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = DP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.status != ST_OK) begin
          state_nxt = S_FINISH;
        end else begin
          unique case (stat.op)
            OP_PUSH: begin
              cmd       = DP_PUSH;
              state_nxt = S_FINISH;
            end
            OP_INSERT: begin
              if (stat.ins_end) begin
                cmd       = DP_INS_PLACE;
                state_nxt = S_FINISH;
              end else begin
                cmd       = DP_INS_START;
                state_nxt = S_INS_SHIFT;
              end
            end
            OP_ERASE: begin
              cmd       = DP_ERS_START;
              state_nxt = S_ERS_FIRST;
            end
            OP_POP: begin
              cmd       = DP_POP_START;
              state_nxt = S_ERS_FIRST;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_INS_SHIFT: begin
        cmd = DP_INS_STEP;
        if (stat.up_last) begin
          state_nxt = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        cmd       = DP_INS_PLACE;
        state_nxt = S_FINISH;
      end
      S_ERS_FIRST: begin
        cmd       = DP_ERS_FIRST;
        state_nxt = stat.dn_more1 ? S_ERS_SHIFT : S_FINISH;
      end
      S_ERS_SHIFT: begin
        cmd = DP_ERS_STEP;
        if (!stat.dn_more2) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd       = DP_OUTPUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == DP_OUTPUT) |-> stat.out_free)
    else $error("result loaded while previous result still pending");

  a_capture_goes_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  a_error_skips_memory: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && stat.status != ST_OK) |=> (state_r == S_FINISH))
    else $error("failed request entered a shift sequence");

endmodule

@@ hw/rtl/ilie_dp.sv @@
// list datapath: element memory, count, cursor and result registers
module ilie_dp #(
  parameter int CAPACITY = ilie_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ilie_pkg::dp_cmd_t                   cmd,
  output ilie_pkg::dp_stat_t                  stat,
  input  ilie_pkg::op_t                       in_op,
  input  logic signed [ilie_pkg::VALUE_W-1:0] in_value,
  input  logic [ilie_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ilie_pkg::status_t                   out_status,
  output logic signed [ilie_pkg::VALUE_W-1:0] out_removed_value,
  output logic [ilie_pkg::COUNT_W-1:0]        out_count
);
  import ilie_pkg::*;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W  = CNT_W + 1;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [ADDR_W-1:0]         cursor_r, cursor_nxt;
  logic signed [VALUE_W-1:0] removed_r, removed_nxt;
  logic                      out_valid_r, out_valid_nxt;
  op_t                       op_r;
  status_t                   stat_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]          pos_r;
  status_t                   out_status_r;
  logic signed [VALUE_W-1:0] out_removed_r;
  logic [COUNT_W-1:0]        out_count_r;

  logic                      we, re;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [VALUE_W-1:0]        wdata, rdata;

  logic                      full, empty, pos_gt, pos_ge;
  status_t                   chk;
  logic [ADDR_W-1:0]         count_a, pos_a;
  logic [EXT_W-1:0]          cur_e, cnt_e;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_gt  = (CMP_W'(in_position) > CMP_W'(count_r));
  assign pos_ge  = (CMP_W'(in_position) >= CMP_W'(count_r));
  assign count_a = ADDR_W'(count_r);
  assign pos_a   = ADDR_W'(pos_r);
  assign cur_e   = EXT_W'(cursor_r);
  assign cnt_e   = EXT_W'(count_r);

  always_comb begin
    unique case (in_op)
      OP_PUSH:   chk = full ? ST_FULL : ST_OK;
      OP_INSERT: chk = full ? ST_FULL : (pos_gt ? ST_RANGE : ST_OK);
      OP_ERASE:  chk = empty ? ST_EMPTY : (pos_ge ? ST_RANGE : ST_OK);
      OP_POP:    chk = empty ? ST_EMPTY : ST_OK;
      default:   chk = ST_OK;
    endcase
  end

  always_comb begin
    stat.op       = op_r;
    stat.status   = stat_r;
    stat.ins_end  = (CMP_W'(pos_r) == CMP_W'(count_r));
    stat.up_last  = (cursor_r == pos_a + ADDR_W'(1));
    stat.dn_more1 = ((cur_e + EXT_W'(1)) < cnt_e);
    stat.dn_more2 = ((cur_e + EXT_W'(2)) < cnt_e);
    stat.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = cursor_r;
    wdata         = rdata;
    re            = 1'b0;
    raddr         = cursor_r;
    unique case (cmd)
      DP_NOP:     ;
      DP_CAPTURE: removed_nxt = '0;
      DP_PUSH: begin
        we        = 1'b1;
        waddr     = count_a;
        wdata     = value_r;
        count_nxt = count_r + CNT_W'(1);
      end
      DP_INS_START: begin
        re         = 1'b1;
        raddr      = count_a - ADDR_W'(1);
        cursor_nxt = count_a;
      end
      DP_INS_STEP: begin
        we         = 1'b1;
        waddr      = cursor_r;
        wdata      = rdata;
        cursor_nxt = cursor_r - ADDR_W'(1);
        re         = !stat.up_last;
        raddr      = cursor_r - ADDR_W'(2);
      end
      DP_INS_PLACE: begin
        we        = 1'b1;
        waddr     = pos_a;
        wdata     = value_r;
        count_nxt = count_r + CNT_W'(1);
      end
      DP_ERS_START: begin
        re         = 1'b1;
        raddr      = pos_a;
        cursor_nxt = pos_a;
      end
      DP_POP_START: begin
        re         = 1'b1;
        raddr      = count_a - ADDR_W'(1);
        cursor_nxt = count_a - ADDR_W'(1);
      end
      DP_ERS_FIRST: begin
        removed_nxt = rdata;
        re          = stat.dn_more1;
        raddr       = cursor_r + ADDR_W'(1);
        if (!stat.dn_more1) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      DP_ERS_STEP: begin
        we         = 1'b1;
        waddr      = cursor_r;
        wdata      = rdata;
        cursor_nxt = cursor_r + ADDR_W'(1);
        re         = stat.dn_more2;
        raddr      = cursor_r + ADDR_W'(2);
        if (!stat.dn_more2) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      DP_OUTPUT:  out_valid_nxt = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r  <= cursor_nxt;
    removed_r <= removed_nxt;
    if (cmd == DP_CAPTURE) begin
      op_r    <= in_op;
      stat_r  <= chk;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd == DP_OUTPUT) begin
      out_status_r  <= stat_r;
      out_removed_r <= removed_r;
      out_count_r   <= COUNT_W'(count_r);
    end
  end

  ilie_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_count         = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_port_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("read and write to the same entry in one cycle");

  a_failed_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_removed_r == '0))
    else $error("failed request returned a nonzero value");

endmodule

@@ hw/rtl/indexed_list_insert_erase.sv @@
// top level of the indexed list with push, insert, erase and pop
// Usage:
//   in_ch carries one request per transfer: op, value and position. out_ch
//   returns exactly one result per request: status, removed_value and the
//   element count after the request. Both channels transfer on valid && ready.
//   One request is worked at a time; in_ch.ready is high only while the
//   sequencer is idle, and a request may be taken while the previous result
//   still waits in the output register.
// Sequence from request transfer to result valid:
//   rejected request              capture, decode, finish
//   push, insert at the tail      capture, decode writes, finish
//   insert at position p          capture, decode reads the last entry,
//                                 each step moves one entry up,
//                                 place writes the value, finish
//   pop, erase at position p      capture, decode reads the entry,
//                                 first takes it, shift down, finish
//   shift steps do one read and one write of element memory per cycle
// Reset: rst_n low for one edge empties the list; memory contents are not
//   cleared and no clearing pass is needed.
// Stall: when out_ch.ready is low the result holds and the next result waits
//   in its final cycle until the output register frees.
module indexed_list_insert_erase #(
  parameter int CAPACITY = ilie_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ilie_req_if.sink   in_ch,
  ilie_rsp_if.source out_ch
);
  import ilie_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilie_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ilie_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_ch.op),
    .in_value         (in_ch.value),
    .in_position      (in_ch.position),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_removed_value(out_ch.removed_value),
    .out_count        (out_ch.count)
  );

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the indexed list block: random and directed requests
`timescale 1ns / 100ps

module testbench;
  import ilie_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int TOTAL_REQUESTS = 1700;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    status_t                     status;
    logic signed [VALUE_W-1:0]   removed;
    logic [COUNT_W-1:0]          count;
  } list_result_t;

  class list_tracker;
    logic signed [VALUE_W-1:0] words [LIST_CAP];
    int                        fill;
    list_result_t              due_results [$];
    int                        errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function int stored();
      return fill;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    // accepted request: update the list copy and queue its result
    function void apply_request(op_t op, logic signed [VALUE_W-1:0] value,
                                logic [POS_W-1:0] position);
      list_result_t res;
      res.status = ST_OK;
      res.removed = '0;
      case (op)
        OP_PUSH: begin
          if (fill >= LIST_CAP) begin
            res.status = ST_FULL;
          end else begin
            words[fill] = value;
            fill++;
          end
        end
        OP_INSERT: begin
          if (fill >= LIST_CAP) begin
            res.status = ST_FULL;
          end else if (int'(position) > fill) begin
            res.status = ST_RANGE;
          end else begin
            for (int i = fill; i > int'(position); i--) words[i] = words[i-1];
            words[position] = value;
            fill++;
          end
        end
        OP_ERASE: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else if (int'(position) >= fill) begin
            res.status = ST_RANGE;
          end else begin
            res.removed = words[position];
            for (int i = int'(position); i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        default: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.removed = words[fill-1];
            fill--;
          end
        end
      endcase
      res.count = fill[COUNT_W-1:0];
      due_results.push_back(res);
    endfunction

    function void check_result(status_t status, logic signed [VALUE_W-1:0] removed,
                               logic [COUNT_W-1:0] count);
      list_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with none expected: status %0d removed %0d count %0d",
                   status, removed, count);
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status || removed !== want.removed || count !== want.count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d removed %0d count %0d, got %0d %0d %0d",
                   want.status, want.removed, want.count, status, removed, count);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          long_hold;
  bit          src_quiet;
  int          issued;
  list_tracker tracker;

  ilie_req_if req ();
  ilie_rsp_if rsp ();

  indexed_list_insert_erase DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req),
    .out_ch (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready)
      tracker.check_result(rsp.status, rsp.removed_value, rsp.count);
  end

  initial begin : sink_side
    int stall_left;
    int quiet_left;
    int r;
    bit quiet;
    rsp.ready = 1'b0;
    stall_left = 0;
    quiet_left = 0;
    quiet = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp.ready = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      if (quiet_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        quiet_left = $urandom_range(50, 400);
      end
      quiet_left--;
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready = 1'b0;
      end else if (quiet) begin
        rsp.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          stall_left = (r < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2);
          rsp.ready = 1'b0;
        end else begin
          rsp.ready = 1'b1;
        end
      end
    end
  end

  // holds the request until its transfer, then books it
  task automatic send_request(op_t op, logic signed [VALUE_W-1:0] value,
                              logic [POS_W-1:0] position);
    @(negedge clk);
    req.valid = 1'b1;
    req.op = op;
    req.value = value;
    req.position = position;
    do @(posedge clk); while (!req.ready);
    tracker.apply_request(op, value, position);
    issued++;
  endtask

  task automatic sender_idle(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      req.op = op_t'($urandom_range(0, 3));
      req.value = $urandom;
      req.position = POS_W'($urandom);
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic request(op_t op, logic signed [VALUE_W-1:0] value,
                         logic [POS_W-1:0] position);
    int r;
    send_request(op, value, position);
    r = $urandom_range(0, 99);
    if (src_quiet || r < 55)
      sender_idle(0);
    else if (r < 90)
      sender_idle($urandom_range(1, 3));
    else if (r < 97)
      sender_idle($urandom_range(4, 10));
    else
      sender_idle($urandom_range(20, 60));
  endtask

  task automatic wait_all_results();
    sender_idle(1);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0;
      3:       return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request(int grow_pct);
    int n;
    logic [POS_W-1:0] pos;
    n = tracker.stored();
    if ($urandom_range(0, 99) < grow_pct) begin
      if ($urandom_range(0, 1)) begin
        request(OP_PUSH, pick_value(), POS_W'($urandom));
      end else begin
        if ($urandom_range(0, 19) == 0)
          pos = POS_W'($urandom_range(n + 1, 511));
        else
          pos = POS_W'($urandom_range(0, n));
        request(OP_INSERT, pick_value(), pos);
      end
    end else begin
      if ($urandom_range(0, 1)) begin
        request(OP_POP, $urandom, POS_W'($urandom));
      end else begin
        if (n == 0 || $urandom_range(0, 19) == 0)
          pos = POS_W'($urandom_range(n, 511));
        else
          pos = POS_W'($urandom_range(0, n - 1));
        request(OP_ERASE, $urandom, pos);
      end
    end
  endtask

  // fill to capacity, probe the full list, then empty it again
  task automatic fill_then_empty();
    src_quiet = 1'b0;
    while (tracker.stored() < LIST_CAP) random_request(100);
    request(OP_PUSH, pick_value(), 9'd0);
    request(OP_INSERT, pick_value(), 9'd511);
    request(OP_INSERT, pick_value(), 9'd0);
    request(OP_ERASE, 32'sd0, 9'd256);
    request(OP_ERASE, 32'sd0, 9'd255);
    request(OP_INSERT, pick_value(), 9'd0);
    request(OP_ERASE, 32'sd0, 9'd0);
    request(OP_INSERT, pick_value(), 9'd255);
    while (tracker.stored() > 0) random_request(0);
    request(OP_POP, 32'sd0, 9'd0);
  endtask

  initial begin : stimulus
    int grow_pct;
    int span;
    bit filled;
    tracker = new();
    issued = 0;
    long_hold = 1'b0;
    src_quiet = 1'b0;
    filled = 1'b0;
    req.valid = 1'b0;
    req.op = OP_PUSH;
    req.value = '0;
    req.position = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list and range corners
    request(OP_POP, 32'sd0, 9'd0);
    request(OP_ERASE, 32'sd0, 9'd0);
    request(OP_ERASE, 32'sd0, 9'd511);
    request(OP_INSERT, 32'sd5, 9'd1);
    request(OP_INSERT, 32'sh8000_0000, 9'd0);
    request(OP_PUSH, 32'sh7fff_ffff, 9'd511);
    request(OP_PUSH, -32'sd1, 9'd0);
    request(OP_INSERT, 32'sd0, 9'd3);
    request(OP_INSERT, 32'sh5a5a_5a5a, 9'd1);
    request(OP_INSERT, 32'sd7, 9'd511);
    request(OP_INSERT, 32'sd7, 9'd6);
    request(OP_ERASE, 32'sd0, 9'd5);
    request(OP_ERASE, 32'sd0, 9'd0);
    request(OP_ERASE, 32'sd0, 9'd2);
    request(OP_ERASE, 32'sd0, 9'd2);
    request(OP_POP, 32'sd0, 9'd0);
    request(OP_POP, 32'sd0, 9'd0);
    request(OP_POP, 32'sd0, 9'd0);
    wait_all_results();

    // sink holds off at first while random requests keep coming
    long_hold = 1'b1;
    while (issued < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 2))
        0:       grow_pct = 35;
        1:       grow_pct = 50;
        default: grow_pct = 65;
      endcase
      span = $urandom_range(40, 160);
      src_quiet = ($urandom_range(0, 3) == 0);
      repeat (span) random_request(grow_pct);
      if (tracker.stored() > 96)
        repeat (tracker.stored() / 2) random_request(20);
      if ($urandom_range(0, 3) == 0)
        wait_all_results();
      if (!filled && issued > 600) begin
        fill_then_empty();
        filled = 1'b1;
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
